// ----- design/dwpi_pkg.sv -----
package dwpi_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int ACC_WIDTH_DEF      = 32;

  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 15;
  localparam int ERR_W   = SPEED_W + 2;
  localparam int PROD_W  = GAIN_W + 1 + ERR_W;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST    = DUTY_W'(8000);
  localparam logic [DUTY_W-1:0] OVERRIDE_DUTY_RST = DUTY_W'(4000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN     = 2'd0,
    CFG_INT_GAIN      = 2'd1,
    CFG_DUTY_LIMIT    = 2'd2,
    CFG_OVERRIDE_DUTY = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic clear_state;
  } lane_ctrl_t;

  typedef struct packed {
    logic              neg;
    logic [DUTY_W-1:0] mag;
  } lane_duty_t;

  typedef struct packed {
    logic load;
    logic force_drive;
  } merge_ctrl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_forward;
    logic [DUTY_W-1:0] left_reverse;
    logic [DUTY_W-1:0] right_forward;
    logic [DUTY_W-1:0] right_reverse;
  } out_payload_t;

endpackage

// ----- design/dwpi_in_if.sv -----
interface dwpi_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dwpi_pkg::SPEED_W-1:0] target_left;
  logic signed [dwpi_pkg::SPEED_W-1:0] speed_left;
  logic signed [dwpi_pkg::SPEED_W-1:0] target_right;
  logic signed [dwpi_pkg::SPEED_W-1:0] speed_right;
  logic                                force_drive;
  logic                                clear_state;

  modport source (
    output valid, target_left, speed_left, target_right, speed_right,
           force_drive, clear_state,
    input  ready
  );

  modport sink (
    input  valid, target_left, speed_left, target_right, speed_right,
           force_drive, clear_state,
    output ready
  );
endinterface

// ----- design/dwpi_out_if.sv -----
interface dwpi_out_if;
  logic                         valid;
  logic                         ready;
  logic [dwpi_pkg::DUTY_W-1:0]  left_forward;
  logic [dwpi_pkg::DUTY_W-1:0]  left_reverse;
  logic [dwpi_pkg::DUTY_W-1:0]  right_forward;
  logic [dwpi_pkg::DUTY_W-1:0]  right_reverse;

  modport source (
    output valid, left_forward, left_reverse, right_forward, right_reverse,
    input  ready
  );

  modport sink (
    input  valid, left_forward, left_reverse, right_forward, right_reverse,
    output ready
  );
endinterface

// ----- design/dwpi_lane.sv -----
module dwpi_lane #(
  parameter int GAIN_FRAC_BITS = dwpi_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = dwpi_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwpi_pkg::lane_ctrl_t                ctrl,
  input  logic signed [dwpi_pkg::SPEED_W-1:0] target,
  input  logic signed [dwpi_pkg::SPEED_W-1:0] speed,
  input  logic [dwpi_pkg::GAIN_W-1:0]         prop_gain,
  input  logic [dwpi_pkg::GAIN_W-1:0]         int_gain,
  input  logic [dwpi_pkg::DUTY_W-1:0]         duty_limit,
  output dwpi_pkg::lane_duty_t                duty
);

  localparam int ERR_W  = dwpi_pkg::ERR_W;
  localparam int PROD_W = dwpi_pkg::PROD_W;
  localparam int SPD_W  = dwpi_pkg::SPEED_W;
  localparam int DUTY_W = dwpi_pkg::DUTY_W;
  localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;
  localparam int MAG_W  = ACC_WIDTH + 1 - GAIN_FRAC_BITS;
  localparam int CMP_W  = (MAG_W > DUTY_W) ? MAG_W : DUTY_W;

  logic signed [SPD_W-1:0]      tgt_clamp;
  logic signed [ERR_W-1:0]      err;
  logic signed [ERR_W-1:0]      delta;
  logic signed [dwpi_pkg::GAIN_W:0] pg_s;
  logic signed [dwpi_pkg::GAIN_W:0] ig_s;
  logic signed [PROD_W-1:0]     prop_prod;
  logic signed [PROD_W-1:0]     int_prod;

  logic signed [ERR_W-1:0]      prev_err_r;
  logic signed [PROD_W-1:0]     prop_prod_r;
  logic signed [PROD_W-1:0]     int_prod_r;
  logic                         clr_r;

  logic signed [SUM_W-1:0]      acc_sum;
  logic [SUM_W-ACC_WIDTH:0]     sum_hi;
  logic signed [ACC_WIDTH-1:0]  acc_nxt;
  logic signed [ACC_WIDTH-1:0]  acc_r;

  logic [ACC_WIDTH:0]           acc_ext;
  logic [ACC_WIDTH:0]           acc_abs;
  logic [CMP_W-1:0]             mag_ext;
  logic [CMP_W-1:0]             lim_ext;

  // Stage 1: error, change in error and both gain products
  assign tgt_clamp = target[SPD_W-1] ? '0 : target;
  assign err   = {{(ERR_W-SPD_W){tgt_clamp[SPD_W-1]}}, tgt_clamp}
               - {{(ERR_W-SPD_W){speed[SPD_W-1]}}, speed};
  assign delta = err - prev_err_r;
  assign pg_s  = $signed({1'b0, prop_gain});
  assign ig_s  = $signed({1'b0, int_gain});
  assign prop_prod = PROD_W'(pg_s) * PROD_W'(delta);
  assign int_prod  = PROD_W'(ig_s) * PROD_W'(err);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (ctrl.s1_load) begin
      prev_err_r <= ctrl.clear_state ? '0 : err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      prop_prod_r <= prop_prod;
      int_prod_r  <= int_prod;
      clr_r       <= ctrl.clear_state;
    end
  end

  // Stage 2: saturating accumulate
  assign acc_sum = SUM_W'(acc_r) + SUM_W'(prop_prod_r) + SUM_W'(int_prod_r);
  assign sum_hi  = acc_sum[SUM_W-1:ACC_WIDTH-1];

  always_comb begin
    if ((&sum_hi) || !(|sum_hi)) begin
      acc_nxt = acc_sum[ACC_WIDTH-1:0];
    end else if (acc_sum[SUM_W-1]) begin
      acc_nxt = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.s2_load) begin
      acc_r <= clr_r ? '0 : acc_nxt;
    end
  end

  // Duty: truncate toward zero, then clamp the magnitude to the limit
  assign acc_ext = {acc_r[ACC_WIDTH-1], acc_r};
  assign acc_abs = acc_r[ACC_WIDTH-1] ? -acc_ext : acc_ext;
  assign mag_ext = CMP_W'(acc_abs[ACC_WIDTH:GAIN_FRAC_BITS]);
  assign lim_ext = CMP_W'(duty_limit);

  assign duty.neg = acc_r[ACC_WIDTH-1];
  assign duty.mag = (mag_ext > lim_ext) ? duty_limit : mag_ext[DUTY_W-1:0];

endmodule

// ----- design/dwpi_merge.sv -----
module dwpi_merge (
  input  logic                        clk,
  input  dwpi_pkg::merge_ctrl_t       ctrl,
  input  dwpi_pkg::lane_duty_t        lane_l_duty,
  input  dwpi_pkg::lane_duty_t        lane_r_duty,
  input  logic [dwpi_pkg::DUTY_W-1:0] duty_limit,
  input  logic [dwpi_pkg::DUTY_W-1:0] override_duty,
  output dwpi_pkg::out_payload_t      payload
);

  logic [dwpi_pkg::DUTY_W-1:0] forced_duty;
  dwpi_pkg::out_payload_t      payload_nxt;
  dwpi_pkg::out_payload_t      payload_r;

  assign forced_duty = (override_duty < duty_limit) ? override_duty : duty_limit;

  always_comb begin
    if (ctrl.force_drive) begin
      payload_nxt.left_forward  = forced_duty;
      payload_nxt.left_reverse  = '0;
      payload_nxt.right_forward = forced_duty;
      payload_nxt.right_reverse = '0;
    end else begin
      payload_nxt.left_forward  = lane_l_duty.neg ? '0 : lane_l_duty.mag;
      payload_nxt.left_reverse  = lane_l_duty.neg ? lane_l_duty.mag : '0;
      payload_nxt.right_forward = lane_r_duty.neg ? '0 : lane_r_duty.mag;
      payload_nxt.right_reverse = lane_r_duty.neg ? lane_r_duty.mag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      payload_r <= payload_nxt;
    end
  end

  assign payload = payload_r;

endmodule

// ----- design/dual_wheel_incremental_pi_drive.sv -----
// Two-wheel incremental PI speed controller with H-bridge duty split. Takes one
// transaction per clock unless stalled; results pass the product, accumulator
// and merge registers. The rate is set by the per-wheel accumulate-and-saturate
// register, which closes on itself. Each wheel runs in its own
// lane (error and gain products, then the Q(ACC_WIDTH-GAIN_FRAC_BITS).frac
// accumulator); a merge stage splits the clamped duties into forward/reverse
// and applies the forced-drive override. A set clear_state flag zeroes both
// wheels' PI state for that transaction. Write configuration only while no
// transaction is in flight. There is no clearing pass after reset.
module dual_wheel_incremental_pi_drive #(
  parameter int GAIN_FRAC_BITS = dwpi_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = dwpi_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dwpi_in_if.sink                           in_tr,
  dwpi_out_if.source                        out_tr,
  input  logic                              cfg_we,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dwpi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DUTY_W = dwpi_pkg::DUTY_W;
  localparam int GAIN_W = dwpi_pkg::GAIN_W;

  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] int_gain_r;
  logic [DUTY_W-1:0] duty_limit_r;
  logic [DUTY_W-1:0] override_duty_r;

  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic s1_force_r, s2_force_r;
  logic s1_en, s2_en, s3_en;
  logic in_acc;

  dwpi_pkg::lane_ctrl_t   lane_ctrl;
  dwpi_pkg::merge_ctrl_t  merge_ctrl;
  dwpi_pkg::lane_duty_t   lane_l_duty, lane_r_duty;
  dwpi_pkg::out_payload_t payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= '0;
      int_gain_r      <= '0;
      duty_limit_r    <= dwpi_pkg::DUTY_LIMIT_RST;
      override_duty_r <= dwpi_pkg::OVERRIDE_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dwpi_pkg::CFG_PROP_GAIN:     prop_gain_r     <= cfg_wdata[GAIN_W-1:0];
        dwpi_pkg::CFG_INT_GAIN:      int_gain_r      <= cfg_wdata[GAIN_W-1:0];
        dwpi_pkg::CFG_DUTY_LIMIT:    duty_limit_r    <= cfg_wdata[DUTY_W-1:0];
        dwpi_pkg::CFG_OVERRIDE_DUTY: override_duty_r <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage advances when the one after it is empty or moving
  assign s3_en  = !out_vld_r || out_tr.ready;
  assign s2_en  = !s2_vld_r || s3_en;
  assign s1_en  = !s1_vld_r || s2_en;
  assign in_acc = in_tr.valid && s1_en;
  assign in_tr.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r  <= in_tr.valid;
      if (s2_en) s2_vld_r  <= s1_vld_r;
      if (s3_en) out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_force_r <= in_tr.force_drive;
    if (s1_vld_r && s2_en) s2_force_r <= s1_force_r;
  end

  assign lane_ctrl.s1_load     = in_acc;
  assign lane_ctrl.s2_load     = s1_vld_r && s2_en;
  assign lane_ctrl.clear_state = in_tr.clear_state;

  dwpi_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_lane_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lane_ctrl),
    .target     (in_tr.target_left),
    .speed      (in_tr.speed_left),
    .prop_gain  (prop_gain_r),
    .int_gain   (int_gain_r),
    .duty_limit (duty_limit_r),
    .duty       (lane_l_duty)
  );

  dwpi_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_lane_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lane_ctrl),
    .target     (in_tr.target_right),
    .speed      (in_tr.speed_right),
    .prop_gain  (prop_gain_r),
    .int_gain   (int_gain_r),
    .duty_limit (duty_limit_r),
    .duty       (lane_r_duty)
  );

  assign merge_ctrl.load        = s2_vld_r && s3_en;
  assign merge_ctrl.force_drive = s2_force_r;

  dwpi_merge u_merge (
    .clk           (clk),
    .ctrl          (merge_ctrl),
    .lane_l_duty   (lane_l_duty),
    .lane_r_duty   (lane_r_duty),
    .duty_limit    (duty_limit_r),
    .override_duty (override_duty_r),
    .payload       (payload)
  );

  assign out_tr.valid         = out_vld_r;
  assign out_tr.left_forward  = payload.left_forward;
  assign out_tr.left_reverse  = payload.left_reverse;
  assign out_tr.right_forward = payload.right_forward;
  assign out_tr.right_reverse = payload.right_reverse;

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tr.valid)
    else $error("result valid right after reset");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_tr.valid |-> !(out_tr.left_forward != '0 && out_tr.left_reverse != '0) &&
                     !(out_tr.right_forward != '0 && out_tr.right_reverse != '0))
    else $error("both bridge directions driven on one wheel");

  a_forced_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (merge_ctrl.load && merge_ctrl.force_drive) |=>
      (out_tr.left_reverse == '0 && out_tr.right_reverse == '0 &&
       out_tr.left_forward == out_tr.right_forward))
    else $error("forced drive result not symmetric forward");

endmodule
